>>> src/four_level_page_walk_translator_top_defines.svh
// assertion macros for the page walk translator
`ifndef FOUR_LEVEL_PAGE_WALK_TRANSLATOR_TOP_DEFINES_SVH
`define FOUR_LEVEL_PAGE_WALK_TRANSLATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FLPWT_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FLPWT_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> src/flpwt_pkg.sv
// types, codes and helpers shared by the page walk translator
`default_nettype none
package flpwt_pkg;

  localparam int VA_W    = 48;
  localparam int ROOT_W  = 52;
  localparam int ENTRY_W = 64;
  localparam int ADDR_W  = 64;
  localparam int IDX_W   = 9;

  typedef logic [VA_W-1:0]    va_t;
  typedef logic [ROOT_W-1:0]  root_t;
  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [2:0]         level_t;

  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_RESPONSE  = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam level_t LEVEL_IDLE = 3'd0;
  localparam level_t LEVEL_1    = 3'd1;
  localparam level_t LEVEL_2    = 3'd2;
  localparam level_t LEVEL_3    = 3'd3;
  localparam level_t LEVEL_4    = 3'd4;

  localparam int PRESENT_BIT = 0;
  localparam int LARGE_BIT   = 7;

  localparam addr_t LOW12_MASK = 64'h0000_0000_0000_0FFF;
  localparam addr_t LOW21_MASK = 64'h0000_0000_001F_FFFF;

  // table index of the virtual address for a given level
  function automatic idx_t table_index(input va_t va, input level_t lvl);
    idx_t idx;
    unique case (lvl)
      LEVEL_1: idx = va[47:39];
      LEVEL_2: idx = va[38:30];
      LEVEL_3: idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  // entry address inside a table
  function automatic addr_t entry_address(input addr_t base, input idx_t idx);
    return base + {{(ADDR_W-IDX_W-3){1'b0}}, idx, 3'b000};
  endfunction

endpackage
`default_nettype wire

>>> src/flpwt_channels.sv
// valid/ready channel interfaces for requests and results
`default_nettype none
interface flpwt_req_if;
  import flpwt_pkg::*;
  logic   valid;
  logic   ready;
  logic   req_type;
  va_t    virtual_address;
  entry_t entry_data;

  modport source (output valid, req_type, virtual_address, entry_data, input ready);
  modport sink   (input valid, req_type, virtual_address, entry_data, output ready);
endinterface

interface flpwt_res_if;
  import flpwt_pkg::*;
  logic  valid;
  logic  ready;
  logic  result_kind;
  addr_t read_address;
  addr_t physical_address;
  logic  found;

  modport source (output valid, result_kind, read_address, physical_address, found,
                  input ready);
  modport sink   (input valid, result_kind, read_address, physical_address, found,
                  output ready);
endinterface
`default_nettype wire

>>> src/four_level_page_walk_translator_top.sv
// four-level page table walker with a registered result stage
//
// req carries either a translate request (req_type 0, virtual_address) or a
// memory response (req_type 1, entry_data). every request gives exactly one
// result on res: a memory read of the next table entry (result_kind 0) or a
// finished translation (result_kind 1, physical_address, found).
// the result is registered and appears in the cycle after the request is
// taken. one request is taken every cycle while res.ready is high; the rate
// is set by the single result register, refilled in the cycle it drains.
// a stalled receiver holds the result; req.ready drops only while the
// result register is full and res.ready is low.
// cfg_write_enable loads root_table_address from cfg_write_data; write it
// while the block is idle.
// synchronous reset clears the walk level to idle, the held address and the
// root address, and empties the result register.
`default_nettype none
`include "four_level_page_walk_translator_top_defines.svh"
module four_level_page_walk_translator_top (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_write_enable,
  input  wire flpwt_pkg::root_t cfg_write_data,
  flpwt_req_if.sink             req,
  flpwt_res_if.source           res
);
  import flpwt_pkg::*;

  root_t  root_table_address;
  level_t walk_level;
  level_t walk_level_next;
  va_t    held_virtual_address;
  va_t    held_virtual_address_next;

  logic   res_valid;
  logic   kind_next;
  addr_t  read_address_next;
  addr_t  physical_address_next;
  logic   found_next;
  logic   accept;
  addr_t  next_base;

  assign req.ready = !res_valid || res.ready;
  assign accept    = req.valid && req.ready;
  assign res.valid = res_valid;
  assign next_base = req.entry_data & ~LOW12_MASK;

  always_comb begin
    walk_level_next           = walk_level;
    held_virtual_address_next = held_virtual_address;
    kind_next                 = KIND_DONE;
    read_address_next         = '0;
    physical_address_next     = '0;
    found_next                = 1'b0;
    if (req.req_type == REQ_TRANSLATE) begin
      held_virtual_address_next = req.virtual_address;
      walk_level_next           = LEVEL_1;
      kind_next                 = KIND_READ;
      read_address_next = entry_address({{(ADDR_W-ROOT_W){1'b0}}, root_table_address},
                                        table_index(req.virtual_address, LEVEL_1));
    end else begin
      walk_level_next = LEVEL_IDLE;
      priority if (walk_level < LEVEL_1 || walk_level > LEVEL_4 ||
                   !req.entry_data[PRESENT_BIT]) begin
        found_next = 1'b0;
      end else if (walk_level == LEVEL_4) begin
        found_next            = 1'b1;
        physical_address_next = next_base |
                                ({{(ADDR_W-VA_W){1'b0}}, held_virtual_address} & LOW12_MASK);
      end else if (walk_level == LEVEL_3 && req.entry_data[LARGE_BIT]) begin
        found_next            = 1'b1;
        physical_address_next = (req.entry_data & ~LOW21_MASK) |
                                ({{(ADDR_W-VA_W){1'b0}}, held_virtual_address} & LOW21_MASK);
      end else begin
        walk_level_next   = walk_level + 3'd1;
        kind_next         = KIND_READ;
        read_address_next = entry_address(next_base,
                                          table_index(held_virtual_address,
                                                      walk_level + 3'd1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_address   <= '0;
      walk_level           <= LEVEL_IDLE;
      held_virtual_address <= '0;
      res_valid            <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        root_table_address <= cfg_write_data;
      end
      if (accept) begin
        walk_level           <= walk_level_next;
        held_virtual_address <= held_virtual_address_next;
        res_valid            <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.result_kind      <= kind_next;
      res.read_address     <= read_address_next;
      res.physical_address <= physical_address_next;
      res.found            <= found_next;
    end
  end

  `FLPWT_ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, res_valid,
                     "accepted request produced no result")
  `FLPWT_ASSERT_NEXT(a_translate_starts_walk, clk, rst,
                     accept && req.req_type == REQ_TRANSLATE,
                     walk_level == LEVEL_1 && res.result_kind == KIND_READ,
                     "translate request did not start a walk")
  `FLPWT_ASSERT_NOW(a_level_in_range, clk, rst, 1'b1, walk_level <= LEVEL_4,
                    "walk level out of range")

endmodule
`default_nettype wire

>>> tb/tb_four_level_page_walk_translator_top.sv
// self-checking testbench for the four-level page walk translator top
module tb_four_level_page_walk_translator_top;
  import flpwt_pkg::*;

  typedef struct packed {
    logic  kind;
    addr_t raddr;
    addr_t paddr;
    logic  found;
  } walk_result_t;

  typedef struct packed {
    logic   rtype;
    va_t    va;
    entry_t entry;
    bit     typed;
    logic   kind;
    addr_t  raddr;
    addr_t  paddr;
    logic   found;
  } dir_row_t;

  localparam int DIR_ROWS    = 25;
  localparam int PHASES      = 4;
  localparam int PHASE_ITEMS = 150;
  localparam int STALL_LIMIT = 2000;

  // directed requests, expected result typed in where obvious
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{REQ_RESPONSE,  48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, KIND_DONE, 64'h0, 64'h0, 1'b0},
    '{REQ_TRANSLATE, 48'h0, 64'h0, 1'b1, KIND_READ, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'h0, 1'b1, KIND_DONE, 64'h0, 64'h0, 1'b0},
    '{REQ_TRANSLATE, 48'hFFFF_FFFF_FFFF, 64'h0, 1'b1, KIND_READ, 64'hFF8, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'h0, 1'b1, KIND_DONE, 64'h0, 64'h0, 1'b0},
    '{REQ_TRANSLATE, 48'h0000_8040_2123, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'h8000_0000_1234_5081, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'h0000_0000_0ABC_D0FF, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'h0000_0001_2345_6001, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'hFFF0_0000_0000_0181, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_TRANSLATE, 48'h1234_5678_9ABC, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_TRANSLATE, 48'hFEDC_BA98_7654, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'h0000_0000_0000_2001, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_TRANSLATE, 48'h0000_0000_0FFF, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'h0000_0000_0000_3001, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'h0, 1'b1, KIND_DONE, 64'h0, 64'h0, 1'b0},
    '{REQ_TRANSLATE, 48'h7FFF_FFFF_FFFF, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'h1, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'h1, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'h1, 1'b0, 1'b0, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, KIND_DONE, 64'h0, 64'h0, 1'b0},
    '{REQ_RESPONSE,  48'h0, 64'h1, 1'b1, KIND_DONE, 64'h0, 64'h0, 1'b0}
  };

  logic  clk;
  logic  rst;
  logic  cfg_write_enable;
  root_t cfg_write_data;

  flpwt_req_if req_ch ();
  flpwt_res_if res_ch ();

  four_level_page_walk_translator_top uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .req              (req_ch),
    .res              (res_ch)
  );

  root_t        model_root;
  level_t       walk_lvl;
  va_t          walk_va;
  walk_result_t pending_results [$];
  bit           typed_now;
  walk_result_t typed_result;
  bit           req_idle_on;
  bit           res_idle_on;
  int           errors;
  int           sent;
  int           reads;
  int           finished;
  int           found_cnt;
  int           root_writes;
  int           quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [8:0] walk_index(input va_t va, input level_t lvl);
    int sh;
    sh = 39 - 9 * (int'(lvl) - 1);
    return 9'((va >> sh) & 48'h1FF);
  endfunction

  // advances the walk state by one request and returns its result
  function automatic walk_result_t next_walk_result(input logic rtype, input va_t va,
                                                    input entry_t entry);
    walk_result_t r;
    addr_t        base;
    r = '0;
    r.kind = KIND_DONE;
    if (rtype == REQ_TRANSLATE) begin
      walk_va  = va;
      walk_lvl = LEVEL_1;
      r.kind   = KIND_READ;
      r.raddr  = addr_t'(model_root) + (addr_t'(walk_index(va, LEVEL_1)) << 3);
    end else if (walk_lvl < LEVEL_1 || walk_lvl > LEVEL_4 || !entry[PRESENT_BIT]) begin
      walk_lvl = LEVEL_IDLE;
    end else if (walk_lvl == LEVEL_4) begin
      walk_lvl = LEVEL_IDLE;
      r.paddr  = (entry & ~LOW12_MASK) | (addr_t'(walk_va) & LOW12_MASK);
      r.found  = 1'b1;
    end else if (walk_lvl == LEVEL_3 && entry[LARGE_BIT]) begin
      walk_lvl = LEVEL_IDLE;
      r.paddr  = (entry & ~LOW21_MASK) | (addr_t'(walk_va) & LOW21_MASK);
      r.found  = 1'b1;
    end else begin
      base     = entry & ~LOW12_MASK;
      walk_lvl = walk_lvl + 3'd1;
      r.kind   = KIND_READ;
      r.raddr  = base + (addr_t'(walk_index(walk_va, walk_lvl)) << 3);
    end
    return r;
  endfunction

  function automatic int draw_wait(input bit on);
    return on ? $urandom_range(0, 19) : 0;
  endfunction

  function automatic va_t rand_va();
    return va_t'({$urandom, $urandom});
  endfunction

  function automatic entry_t rand_entry();
    return {$urandom, $urandom};
  endfunction

  task automatic report_field(input string name, input addr_t want, input addr_t got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // result side and request side, sampled at the rising edge
  always @(posedge clk) begin
    walk_result_t want;
    walk_result_t got;
    bit           moved;
    moved = 1'b0;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        moved = 1'b1;
        got = '{res_ch.result_kind, res_ch.read_address, res_ch.physical_address,
                res_ch.found};
        if (got.kind == KIND_READ) reads++;
        else begin
          finished++;
          if (got.found) found_cnt++;
        end
        if (pending_results.size() == 0) begin
          $error("result with nothing outstanding: kind %0d", got.kind);
          errors++;
        end else begin
          want = pending_results.pop_front();
          report_field("result_kind", addr_t'(want.kind), addr_t'(got.kind));
          report_field("read_address", want.raddr, got.raddr);
          report_field("physical_address", want.paddr, got.paddr);
          report_field("found", addr_t'(want.found), addr_t'(got.found));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        moved = 1'b1;
        want = next_walk_result(req_ch.req_type, req_ch.virtual_address,
                                req_ch.entry_data);
        pending_results.push_back(typed_now ? typed_result : want);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout, %0d results outstanding", pending_results.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result receiver with random stalls
  initial begin
    int n;
    res_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      n = draw_wait(res_idle_on);
      if (n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1 || rst);
      @(negedge clk);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic rtype, input va_t va, input entry_t entry,
                           input bit typed, input walk_result_t typed_res);
    int gap;
    gap = draw_wait(req_idle_on);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= rtype;
    req_ch.virtual_address <= va;
    req_ch.entry_data      <= entry;
    typed_now              <= typed;
    typed_result           <= typed_res;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_root(input root_t value);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    model_root = value;
    root_writes++;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    @(negedge clk);
  endtask

  // mostly well-formed walks, some cut short, plus stray requests
  task automatic run_random(input int count);
    int     stop_at;
    int     sel;
    int     lvl;
    bit     done;
    entry_t e;
    stop_at = sent + count;
    while (sent < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        send_item(REQ_RESPONSE, rand_va(), rand_entry(), 1'b0, '0);
      end else if (sel < 9) begin
        send_item(REQ_TRANSLATE, rand_va(), rand_entry(), 1'b0, '0);
      end else begin
        send_item(REQ_TRANSLATE, rand_va(), rand_entry(), 1'b0, '0);
        done = 1'b0;
        lvl  = 1;
        while (!done) begin
          if ($urandom_range(0, 19) == 0) begin
            done = 1'b1;
          end else begin
            e = rand_entry();
            e[PRESENT_BIT] = ($urandom_range(0, 9) != 0);
            send_item(REQ_RESPONSE, rand_va(), e, 1'b0, '0);
            done = !e[PRESENT_BIT] || lvl == 4 || (lvl == 3 && e[LARGE_BIT]);
            lvl++;
          end
        end
      end
    end
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_write_enable       = 1'b0;
    cfg_write_data         = '0;
    req_ch.valid           = 1'b0;
    req_ch.req_type        = REQ_TRANSLATE;
    req_ch.virtual_address = '0;
    req_ch.entry_data      = '0;
    typed_now              = 1'b0;
    typed_result           = '0;
    req_idle_on            = 1'b1;
    res_idle_on            = 1'b1;
    model_root             = '0;
    walk_lvl               = LEVEL_IDLE;
    walk_va                = '0;
    errors                 = 0;
    sent                   = 0;
    reads                  = 0;
    finished               = 0;
    found_cnt              = 0;
    root_writes            = 0;
    quiet_cycles           = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_rows[i].rtype, dir_rows[i].va, dir_rows[i].entry, dir_rows[i].typed,
                '{dir_rows[i].kind, dir_rows[i].raddr, dir_rows[i].paddr,
                  dir_rows[i].found});
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       write_root('1);
        1:       write_root('0);
        default: write_root(root_t'({$urandom, $urandom}));
      endcase
      req_idle_on = (p != 1);
      res_idle_on = (p != 3);
      run_random(PHASE_ITEMS);
      drain();
    end

    $display("%0d requests under %0d root addresses: %0d table reads, %0d walks ended",
             sent, root_writes + 1, reads, finished);
    $display("%0d translations found, %0d mismatches", found_cnt, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
